// ----- hw/rtl/real_time_target_share_check_assert.svh -----
// Assertion macros used by the share check back end.
`ifndef REAL_TIME_TARGET_SHARE_CHECK_ASSERT_SVH
`define REAL_TIME_TARGET_SHARE_CHECK_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RTTSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RTTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rttsc_pkg.sv -----
// Shared types, constants and functions of the share check.
package rttsc_pkg;

    localparam int DIFF_BITS_DEF      = 24;
    localparam int COEF_FRAC_BITS_DEF = 128;
    localparam int TARGET_W           = 256;
    localparam int TIME_W             = 48;
    localparam int COMPACT_W          = 32;
    localparam int LIMB_W             = 32;
    localparam int NUM_REF            = 4;
    localparam int DIST_POW           = 5;
    localparam int QUEUE_DEPTH        = 2;
    localparam int CFG_IDX_W          = 8;
    localparam int CFG_DATA_W         = 48;
    localparam int S_DATA_W           = 336;
    localparam int M_DATA_W           = 40;
    localparam int COEF_CALC_W        = 768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RTT_EN  = 8'd0,
        CFG_PREV_CT = 8'd1,
        CFG_PREV_T0 = 8'd2,
        CFG_PREV_T1 = 8'd3,
        CFG_PREV_T2 = 8'd4,
        CFG_PREV_T3 = 8'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MULS,
        B_ROW,
        B_CAND,
        B_CAP,
        B_CMP,
        B_ENC,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic [COMPACT_W-1:0] adjusted_compact_target;
        logic                 target_invalid;
        logic                 is_pending_block;
        logic                 is_block;
    } result_t;

    // floor(m * 2^frac / 10^e) for reference block idx
    function automatic logic [COEF_CALC_W-1:0] coef_value(input int idx, input int frac);
        logic [COEF_CALC_W-1:0] v;
        logic [63:0]            m;
        int                     e;
        case (idx)
            0:       begin m = 64'd49192018423; e = 24; end
            1:       begin m = 64'd48039080491; e = 27; end
            2:       begin m = 64'd49192018423; e = 29; end
            default: begin m = 64'd46913164542; e = 30; end
        endcase
        v = COEF_CALC_W'(m) << frac;
        for (int k = 0; k < e; k++) begin
            v = v / 10;
        end
        return v;
    endfunction

    // compact to 256-bit target, sign bit ignored
    function automatic logic [TARGET_W-1:0] expand_compact(input logic [COMPACT_W-1:0] c);
        logic [TARGET_W-1:0] w;
        logic [7:0]          sz;
        logic [7:0]          up;
        logic [1:0]          dn;
        w  = TARGET_W'(c[22:0]);
        sz = c[31:24];
        up = sz - 8'd3;
        dn = 2'(8'd3 - sz);
        if (sz <= 8'd3) begin
            return w >> {dn, 3'b000};
        end
        if (up >= 8'd32) begin
            return '0;
        end
        return w << {up[4:0], 3'b000};
    endfunction

    function automatic logic compact_bad(input logic [COMPACT_W-1:0] c);
        logic [22:0] word;
        logic [7:0]  sz;
        word = c[22:0];
        sz   = c[31:24];
        return (word != '0) && (c[23] || (sz > 8'd34) ||
               ((word > 23'hff) && (sz > 8'd33)) ||
               ((word > 23'hffff) && (sz > 8'd32)));
    endfunction

endpackage

// ----- hw/rtl/rttsc_front.sv -----
// Front end: takes requests, expands the header target and computes age distances.
module rttsc_front #(
    parameter int DIFF_BITS = rttsc_pkg::DIFF_BITS_DEF
) (
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    input  logic [rttsc_pkg::S_DATA_W-1:0]                        s_tdata,
    input  logic [rttsc_pkg::NUM_REF-1:0][rttsc_pkg::TIME_W-1:0]  prev_time,
    input  logic                                                  q_full,
    output logic                                                  q_push,
    output logic [1+2*rttsc_pkg::TARGET_W+rttsc_pkg::NUM_REF*DIFF_BITS-1:0] q_data
);

    localparam int TW = rttsc_pkg::TIME_W;

    logic [TW-1:0]                              now;
    logic [rttsc_pkg::COMPACT_W-1:0]            hc;
    logic [rttsc_pkg::TARGET_W-1:0]             hash;
    logic [rttsc_pkg::TARGET_W-1:0]             hdr;
    logic                                       inv;
    logic [rttsc_pkg::NUM_REF-1:0][DIFF_BITS-1:0] age_dist;

    assign now  = s_tdata[TW-1:0];
    assign hc   = s_tdata[TW +: rttsc_pkg::COMPACT_W];
    assign hash = s_tdata[TW+rttsc_pkg::COMPACT_W +: rttsc_pkg::TARGET_W];
    assign hdr  = rttsc_pkg::expand_compact(hc);
    assign inv  = rttsc_pkg::compact_bad(hc) || (hdr == '0);

    always_comb begin
        logic [TW-1:0] gap;
        for (int r = 0; r < rttsc_pkg::NUM_REF; r++) begin
            if (now > prev_time[r]) begin
                gap = now - prev_time[r];
            end else begin
                gap = TW'(1);
            end
            if (|gap[TW-1:DIFF_BITS]) begin
                age_dist[r] = '1;
            end else begin
                age_dist[r] = gap[DIFF_BITS-1:0];
            end
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_data   = {inv, hdr, hash, age_dist};

endmodule

// ----- hw/rtl/rttsc_queue.sv -----
// Small queue between front and back end.
module rttsc_queue #(
    parameter int W     = 8,
    parameter int DEPTH = rttsc_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/rttsc_back.sv -----
// Back end: limb-serial candidate arithmetic, comparisons and compact encoding.
module rttsc_back #(
    parameter int DIFF_BITS      = rttsc_pkg::DIFF_BITS_DEF,
    parameter int COEF_FRAC_BITS = rttsc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid,
    input  logic [1+2*rttsc_pkg::TARGET_W+rttsc_pkg::NUM_REF*DIFF_BITS-1:0] q_data,
    output logic                                   q_pop,
    input  logic                                   rtt_en,
    input  logic [rttsc_pkg::COMPACT_W-1:0]        prev_ct,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output rttsc_pkg::result_t                     m_res
);

    `include "real_time_target_share_check_assert.svh"

    localparam int TGW     = rttsc_pkg::TARGET_W;
    localparam int LW      = rttsc_pkg::LIMB_W;
    localparam int NREF    = rttsc_pkg::NUM_REF;
    localparam int ENTRY_W = 1 + 2*TGW + NREF*DIFF_BITS;
    localparam int NL      = (TGW + COEF_FRAC_BITS + rttsc_pkg::DIST_POW*DIFF_BITS + LW - 1) / LW;
    localparam int NC      = (COEF_FRAC_BITS + LW - 1) / LW;
    localparam int CW      = NC * LW;
    localparam int IW      = $clog2(NL);
    localparam int JW      = $clog2(NC);
    localparam int KW      = $clog2(NREF);
    localparam int PROD_W  = NL * LW;
    localparam int HASH_LO = NREF * DIFF_BITS;
    localparam int HDR_LO  = HASH_LO + TGW;
    localparam int PREV_L  = TGW / LW;

    localparam logic [CW-1:0] COEF [NREF] = '{
        CW'(rttsc_pkg::coef_value(0, COEF_FRAC_BITS)),
        CW'(rttsc_pkg::coef_value(1, COEF_FRAC_BITS)),
        CW'(rttsc_pkg::coef_value(2, COEF_FRAC_BITS)),
        CW'(rttsc_pkg::coef_value(3, COEF_FRAC_BITS))
    };

    rttsc_pkg::back_state_t state_reg, state_next;

    logic [LW-1:0]      a_reg [NL];
    logic [LW-1:0]      a_next [NL];
    logic [LW-1:0]      r_reg [NL];
    logic [LW-1:0]      r_next [NL];
    logic [LW-1:0]      carry_reg, carry_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [JW-1:0]      j_reg, j_next;
    logic [2:0]         pass_reg, pass_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [TGW:0]       best_reg, best_next;
    logic [ENTRY_W-1:0] ent_reg, ent_next;
    logic [TGW-1:0]     prev_reg, prev_next;
    logic               rtt_reg, rtt_next;
    logic [TGW-1:0]     norm_reg, norm_next;
    logic [5:0]         size_reg, size_next;
    rttsc_pkg::result_t res_reg, res_next;
    rttsc_pkg::result_t m_res_reg;
    logic               m_tvalid_reg;
    logic               out_load;

    logic [TGW-1:0]     prev_exp;
    logic [TGW-1:0]     ent_hdr;
    logic [TGW-1:0]     ent_hash;
    logic [IW-1:0]      a_idx;
    logic [LW-1:0]      a_row;
    logic [LW-1:0]      mul_x, mul_m, add_in;
    logic [2*LW-1:0]    prod, mac;
    logic [PROD_W-1:0]  rflat;
    logic               over;
    logic [TGW:0]       cand;
    logic [23:0]        mant;
    logic [7:0]         sz8;

    assign prev_exp = rttsc_pkg::expand_compact(prev_ct);
    assign ent_hdr  = ent_reg[HDR_LO +: TGW];
    assign ent_hash = ent_reg[HASH_LO +: TGW];

    assign a_idx  = i_reg - IW'(j_reg);
    assign a_row  = (i_reg >= IW'(j_reg)) ? a_reg[a_idx] : '0;
    assign mul_x  = (state_reg == rttsc_pkg::B_ROW) ? a_row : a_reg[0];
    assign mul_m  = (state_reg == rttsc_pkg::B_ROW) ? COEF[k_reg][j_reg*LW +: LW]
                                                    : LW'(ent_reg[k_reg*DIFF_BITS +: DIFF_BITS]);
    assign add_in = (state_reg == rttsc_pkg::B_ROW) ? r_reg[0] : '0;
    assign prod   = mul_x * mul_m;
    assign mac    = prod + {{LW{1'b0}}, add_in} + {{LW{1'b0}}, carry_reg};

    always_comb begin
        for (int x = 0; x < NL; x++) begin
            rflat[x*LW +: LW] = r_reg[x];
        end
    end

    // candidates at or above 2^256 never win over the header target
    assign over = |rflat[PROD_W-1:COEF_FRAC_BITS+TGW];
    assign cand = over ? {1'b1, {TGW{1'b0}}} : {1'b0, rflat[COEF_FRAC_BITS +: TGW]};
    assign mant = norm_reg[TGW-1 -: 24];
    assign sz8  = 8'(size_reg);

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        r_next     = r_reg;
        carry_next = carry_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pass_next  = pass_reg;
        k_next     = k_reg;
        best_next  = best_reg;
        ent_next   = ent_reg;
        prev_next  = prev_reg;
        rtt_next   = rtt_reg;
        norm_next  = norm_reg;
        size_next  = size_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            rttsc_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    ent_next  = q_data;
                    rtt_next  = rtt_en;
                    prev_next = prev_exp;
                    if (q_data[ENTRY_W-1]) begin
                        res_next.adjusted_compact_target = '0;
                        res_next.target_invalid          = 1'b1;
                        res_next.is_pending_block        = 1'b0;
                        res_next.is_block                = 1'b0;
                        state_next = rttsc_pkg::B_OUT;
                    end else if (!rtt_en) begin
                        best_next  = {1'b0, q_data[HDR_LO +: TGW]};
                        state_next = rttsc_pkg::B_CMP;
                    end else begin
                        for (int x = 0; x < NL; x++) begin
                            a_next[x] = (x < PREV_L) ? prev_exp[(x % PREV_L)*LW +: LW] : '0;
                        end
                        i_next     = '0;
                        pass_next  = '0;
                        k_next     = '0;
                        carry_next = '0;
                        state_next = rttsc_pkg::B_MULS;
                    end
                end
            end
            rttsc_pkg::B_MULS: begin
                for (int x = 0; x < NL - 1; x++) begin
                    a_next[x] = a_reg[x+1];
                end
                a_next[NL-1] = mac[LW-1:0];
                carry_next   = mac[2*LW-1:LW];
                if (i_reg == IW'(NL - 1)) begin
                    i_next     = '0;
                    carry_next = '0;
                    if (pass_reg == 3'(rttsc_pkg::DIST_POW - 1)) begin
                        pass_next = '0;
                        j_next    = '0;
                        for (int x = 0; x < NL; x++) begin
                            r_next[x] = '0;
                        end
                        state_next = rttsc_pkg::B_ROW;
                    end else begin
                        pass_next = pass_reg + 1'b1;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            rttsc_pkg::B_ROW: begin
                for (int x = 0; x < NL - 1; x++) begin
                    r_next[x] = r_reg[x+1];
                end
                r_next[NL-1] = mac[LW-1:0];
                carry_next   = mac[2*LW-1:LW];
                if (i_reg == IW'(NL - 1)) begin
                    i_next     = '0;
                    carry_next = '0;
                    if (j_reg == JW'(NC - 1)) begin
                        state_next = rttsc_pkg::B_CAND;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            rttsc_pkg::B_CAND: begin
                if ((k_reg == '0) || (cand < best_reg)) begin
                    best_next = cand;
                end
                if (k_reg == KW'(NREF - 1)) begin
                    state_next = rttsc_pkg::B_CAP;
                end else begin
                    k_next = k_reg + 1'b1;
                    for (int x = 0; x < NL; x++) begin
                        a_next[x] = (x < PREV_L) ? prev_reg[(x % PREV_L)*LW +: LW] : '0;
                    end
                    state_next = rttsc_pkg::B_MULS;
                end
            end
            rttsc_pkg::B_CAP: begin
                if (best_reg >= {1'b0, ent_hdr}) begin
                    best_next = {1'b0, ent_hdr};
                end
                state_next = rttsc_pkg::B_CMP;
            end
            rttsc_pkg::B_CMP: begin
                res_next.is_block         = ({1'b0, ent_hash} <= best_reg);
                res_next.is_pending_block = rtt_reg && (ent_hash <= ent_hdr);
                res_next.target_invalid   = 1'b0;
                norm_next  = best_reg[TGW-1:0];
                size_next  = 6'(TGW / 8);
                state_next = rttsc_pkg::B_ENC;
            end
            rttsc_pkg::B_ENC: begin
                // one byte per cycle until the top byte is nonzero or the size reaches zero
                if ((size_reg != '0) && (norm_reg[TGW-1 -: 8] == '0)) begin
                    norm_next = {norm_reg[TGW-9:0], 8'h00};
                    size_next = size_reg - 1'b1;
                end else begin
                    if (mant[23]) begin
                        res_next.adjusted_compact_target = {sz8 + 8'd1, 8'h00, mant[23:8]};
                    end else begin
                        res_next.adjusted_compact_target = {sz8, mant};
                    end
                    state_next = rttsc_pkg::B_OUT;
                end
            end
            rttsc_pkg::B_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = rttsc_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = rttsc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rttsc_pkg::B_IDLE;
            m_tvalid_reg <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            pass_reg     <= '0;
            k_reg        <= '0;
            carry_reg    <= '0;
            size_reg     <= '0;
            rtt_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pass_reg  <= pass_next;
            k_reg     <= k_next;
            carry_reg <= carry_next;
            size_reg  <= size_next;
            rtt_reg   <= rtt_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        r_reg    <= r_next;
        best_reg <= best_next;
        ent_reg  <= ent_next;
        prev_reg <= prev_next;
        norm_reg <= norm_next;
        res_reg  <= res_next;
        if (out_load) begin
            m_res_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_res    = m_res_reg;

    `RTTSC_ASSERT_NOW(a_invalid_clears, m_tvalid_reg && m_res_reg.target_invalid, !m_res_reg.is_block && !m_res_reg.is_pending_block && (m_res_reg.adjusted_compact_target == '0), "invalid target result carries data")
    `RTTSC_ASSERT_NOW(a_pending_valid, m_tvalid_reg && m_res_reg.is_pending_block, !m_res_reg.target_invalid, "pending flag on invalid target")
    `RTTSC_ASSERT_NOW(a_enc_size, state_reg == rttsc_pkg::B_ENC, size_reg <= 6'(TGW / 8), "compact size out of range")
    `RTTSC_ASSERT_NEXT(a_last_cand, (state_reg == rttsc_pkg::B_CAND) && (k_reg == KW'(NREF - 1)), state_reg == rttsc_pkg::B_CAP, "last candidate not followed by cap")

endmodule

// ----- hw/rtl/real_time_target_share_check.sv -----
// Top level of the real-time-targeting share check.
//
//  channel  | handshake            | payload
//  s_       | s_tvalid / s_tready  | s_tdata: now, header compact, hash
//  m_       | m_tvalid / m_tready  | m_tdata: flags, adjusted compact
//  cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// With real-time targeting on, the single 32x32 multiply-accumulate runs, for each
// of four reference blocks, five distance passes and NC coefficient rows on NL limbs,
// NL = ceil((256+COEF_FRAC_BITS+5*DIFF_BITS)/32), NC = ceil(COEF_FRAC_BITS/32).
// Header-only requests skip this arithmetic; invalid targets go straight to output.
// A two-entry queue takes up to two requests while the back end or m_tready stalls.
// Synchronous active-low reset clears control; configuration resets to zero.
module real_time_target_share_check #(
    parameter int DIFF_BITS      = rttsc_pkg::DIFF_BITS_DEF,
    parameter int COEF_FRAC_BITS = rttsc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_seconds[47:0], header_compact_target[79:48], hash_word_0..3[335:80]
    input  logic [rttsc_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // is_block[0], is_pending_block[1], target_invalid[2],
    // adjusted_compact_target[34:3], zero[39:35]
    output logic [rttsc_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rttsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rttsc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ENTRY_W = 1 + 2*rttsc_pkg::TARGET_W + rttsc_pkg::NUM_REF*DIFF_BITS;
    localparam int RES_W   = $bits(rttsc_pkg::result_t);

    logic                                                 rtt_en_reg;
    logic [rttsc_pkg::COMPACT_W-1:0]                      prev_ct_reg;
    logic [rttsc_pkg::NUM_REF-1:0][rttsc_pkg::TIME_W-1:0] prev_time_reg;

    logic               q_push, q_full, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;
    rttsc_pkg::result_t m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rtt_en_reg    <= 1'b0;
            prev_ct_reg   <= '0;
            prev_time_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rttsc_pkg::CFG_RTT_EN:  rtt_en_reg       <= cfg_data[0];
                rttsc_pkg::CFG_PREV_CT: prev_ct_reg      <= cfg_data[rttsc_pkg::COMPACT_W-1:0];
                rttsc_pkg::CFG_PREV_T0: prev_time_reg[0] <= cfg_data;
                rttsc_pkg::CFG_PREV_T1: prev_time_reg[1] <= cfg_data;
                rttsc_pkg::CFG_PREV_T2: prev_time_reg[2] <= cfg_data;
                rttsc_pkg::CFG_PREV_T3: prev_time_reg[3] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    rttsc_front #(
        .DIFF_BITS (DIFF_BITS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .prev_time (prev_time_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    rttsc_queue #(
        .W     (ENTRY_W),
        .DEPTH (rttsc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_valid)
    );

    rttsc_back #(
        .DIFF_BITS      (DIFF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .rtt_en   (rtt_en_reg),
        .prev_ct  (prev_ct_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {{(rttsc_pkg::M_DATA_W - RES_W){1'b0}}, m_res};

endmodule

// ----- dv/real_time_target_share_check_tb.sv -----
// Self-checking testbench for the real-time-targeting share check: directed and random shares.
module real_time_target_share_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIST_MAX_BITS = 24;
    localparam int FRAC_BITS     = 128;
    localparam int STALL_LIMIT   = 20000;

    typedef struct {
        logic        is_block;
        logic        is_pending_block;
        logic        target_invalid;
        logic [31:0] adjusted_compact_target;
    } verdict_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rttsc_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rttsc_pkg::M_DATA_W-1:0]   m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [rttsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rttsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    verdict_t    pending_verdicts[$];
    int          fail_count = 0;
    int          send_idle_pct = 38;
    int          recv_idle_pct = 57;
    int          quiet_cycles = 0;

    logic        rtt_on = 1'b0;
    logic [31:0] prev_compact = '0;
    logic [47:0] ref_time[4] = '{default: '0};

    real_time_target_share_check u_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---- predictor ----
    function automatic logic [255:0] unpack_target(input logic [31:0] c);
        logic [1023:0] w;
        int            sz;
        sz = c[31:24];
        w  = 1024'(c[22:0]);
        if (sz <= 3) w = w >> (8 * (3 - sz));
        else w = w << (8 * (sz - 3));
        return w[255:0];
    endfunction

    function automatic logic [31:0] pack_target(input logic [255:0] t);
        int          nbits;
        int          sz;
        logic [31:0] cmp;
        nbits = 0;
        for (int i = 0; i < 256; i++) if (t[i]) nbits = i + 1;
        sz = (nbits + 7) / 8;
        if (sz <= 3) cmp = t[31:0] << (8 * (3 - sz));
        else cmp = 32'(t >> (8 * (sz - 3)));
        cmp &= 32'h00ff_ffff;
        if (cmp[23]) begin
            cmp = cmp >> 8;
            sz++;
        end
        return cmp | (32'(sz & 8'hff) << 24);
    endfunction

    function automatic logic [1023:0] rtt_coefficient(input int k);
        logic [1023:0] num;
        logic [1023:0] den;
        logic [63:0]   mant;
        int            ex;
        case (k)
            0: begin mant = 64'd49192018423; ex = 24; end
            1: begin mant = 64'd48039080491; ex = 27; end
            2: begin mant = 64'd49192018423; ex = 29; end
            default: begin mant = 64'd46913164542; ex = 30; end
        endcase
        den = 1;
        for (int i = 0; i < ex; i++) den = den * 10;
        num = 1024'(mant) << FRAC_BITS;
        return num / den;
    endfunction

    function automatic verdict_t judge_share(input logic [47:0] now,
                                             input logic [31:0] hc,
                                             input logic [255:0] hash);
        verdict_t      v;
        logic [255:0]  header;
        logic [22:0]   word;
        logic [7:0]    sz;
        logic          bad;
        logic [1023:0] best;
        logic [1023:0] cand;
        logic [47:0]   d;
        header = unpack_target(hc);
        word = hc[22:0];
        sz = hc[31:24];
        bad = (word != 0) && (hc[23] || sz > 34 || (word > 23'hff && sz > 33) ||
              (word > 23'hffff && sz > 32));
        v = '{1'b0, 1'b0, 1'b0, 32'd0};
        if (bad || header == 0) begin
            v.target_invalid = 1'b1;
            return v;
        end
        if (!rtt_on) begin
            v.is_block = hash <= header;
            v.adjusted_compact_target = pack_target(header);
            return v;
        end
        best = '0;
        for (int k = 0; k < 4; k++) begin
            d = now > ref_time[k] ? now - ref_time[k] : 48'd1;
            if (d > (48'd1 << DIST_MAX_BITS) - 1) d = (48'd1 << DIST_MAX_BITS) - 1;
            cand = 1024'(unpack_target(prev_compact)) * rtt_coefficient(k);
            for (int p = 0; p < 5; p++) cand = cand * 1024'(d);
            cand = cand >> FRAC_BITS;
            if (k == 0 || cand < best) best = cand;
        end
        if (best >= 1024'(header)) best = 1024'(header);
        v.is_block = 1024'(hash) <= best;
        v.is_pending_block = hash <= header;
        v.adjusted_compact_target = pack_target(best[255:0]);
        return v;
    endfunction

    // ---- result checker and watchdog ----
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[0] !== want.is_block) begin
                        $error("is_block exp %0b got %0b", want.is_block, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[1] !== want.is_pending_block) begin
                        $error("is_pending_block exp %0b got %0b",
                               want.is_pending_block, m_tdata[1]);
                        fail_count++;
                    end
                    if (m_tdata[2] !== want.target_invalid) begin
                        $error("target_invalid exp %0b got %0b",
                               want.target_invalid, m_tdata[2]);
                        fail_count++;
                    end
                    if (m_tdata[34:3] !== want.adjusted_compact_target) begin
                        $error("adjusted_compact_target exp %h got %h",
                               want.adjusted_compact_target, m_tdata[34:3]);
                        fail_count++;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---- drivers ----
    task automatic push_share(input logic [47:0] now, input logic [31:0] hc,
                              input logic [255:0] hash);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {hash, hc, now};
        do @(posedge aclk); while (!s_tready);
        pending_verdicts.push_back(judge_share(now, hc, hash));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input rttsc_pkg::cfg_index_t idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rttsc_pkg::CFG_RTT_EN:  rtt_on = val[0];
            rttsc_pkg::CFG_PREV_CT: prev_compact = val[31:0];
            rttsc_pkg::CFG_PREV_T0: ref_time[0] = val;
            rttsc_pkg::CFG_PREV_T1: ref_time[1] = val;
            rttsc_pkg::CFG_PREV_T2: ref_time[2] = val;
            default:                ref_time[3] = val;
        endcase
    endtask

    task automatic apply_setting(input logic en, input logic [31:0] pc,
                                 input logic [47:0] t0, input logic [47:0] t1,
                                 input logic [47:0] t2, input logic [47:0] t3);
        wait_drained();
        write_reg(rttsc_pkg::CFG_RTT_EN, 48'(en));
        write_reg(rttsc_pkg::CFG_PREV_CT, 48'(pc));
        write_reg(rttsc_pkg::CFG_PREV_T0, t0);
        write_reg(rttsc_pkg::CFG_PREV_T1, t1);
        write_reg(rttsc_pkg::CFG_PREV_T2, t2);
        write_reg(rttsc_pkg::CFG_PREV_T3, t3);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [255:0] rand256();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_compact();
        if ($urandom_range(9) == 0) return $urandom;
        return {8'($urandom_range(1, 32)), 1'b0, 23'($urandom)};
    endfunction

    // hash spread around the target so both outcomes occur
    function automatic logic [255:0] rand_hash(input logic [31:0] hc);
        logic [255:0] t;
        t = unpack_target(hc);
        case ($urandom_range(3))
            0: return rand256();
            1: return rand256() >> $urandom_range(255);
            2: return t + 256'($urandom_range(2)) - 256'd1;
            default: return t >> $urandom_range(4);
        endcase
    endfunction

    // ---- tests ----
    task automatic test_invalid_targets();
        push_share(48'd0, 32'h0000_0000, '0);
        push_share(48'd5, 32'h0400_0000, '0);
        push_share(48'd5, 32'h0480_0001, '0);
        push_share(48'd5, 32'h2300_0001, '0);
        push_share(48'd5, 32'h2200_0100, '0);
        push_share(48'd5, 32'h2101_0000, '0);
        push_share(48'd5, 32'h0100_0012, '1);
    endtask

    task automatic test_header_only();
        apply_setting(1'b0, 32'h1d00_ffff, '0, '0, '0, '0);
        push_share('1, 32'h1d00_ffff, '0);
        push_share('0, 32'h1d00_ffff, unpack_target(32'h1d00_ffff));
        push_share('1, 32'h1d00_ffff, unpack_target(32'h1d00_ffff) + 1);
        push_share(48'd9, 32'h207f_ffff, '1);
        push_share(48'd9, 32'h2000_ffff, '1);
        push_share(48'd9, 32'h0300_8000, 256'h7fff);
        push_share(48'd9, 32'h0112_3456, 256'h12);
    endtask

    task automatic test_real_time();
        apply_setting(1'b1, 32'h1c7f_ffff, 48'd1000, 48'd900, 48'd500, 48'd0);
        push_share(48'd1000, 32'h207f_ffff, 256'h1);
        push_share(48'd0, 32'h207f_ffff, rand256() >> 64);
        push_share(48'd1600, 32'h1d00_ffff, rand256() >> 30);
        push_share('1, 32'h207f_ffff, rand256() >> 2);
        apply_setting(1'b1, 32'hffff_ffff, '1, '1, '1, '1);
        push_share('1, 32'h1d00_ffff, '0);
        push_share(48'd7, 32'h2000_ffff, rand256() >> 8);
        apply_setting(1'b1, 32'h0000_0000, '0, '0, '0, '0);
        push_share(48'd77, 32'h1d00_ffff, '0);
        push_share(48'd77, 32'h1d00_ffff, 256'd1);
    endtask

    task automatic test_random_mix(input int sets);
        logic [47:0] base;
        logic [47:0] now;
        logic [31:0] hc;
        for (int s = 0; s < sets; s++) begin
            base = rand48() >> $urandom_range(47);
            apply_setting(1'($urandom_range(1)), rand_compact(), base,
                          base - 48'($urandom_range(600)), base - 48'($urandom_range(20000)),
                          base - (rand48() >> $urandom_range(20, 47)));
            for (int i = 0; i < (rtt_on ? 20 : 40); i++) begin
                case ($urandom_range(3))
                    0: now = rand48();
                    1: now = base - 48'($urandom_range(50));
                    default: now = base + 48'($urandom_range(1, 3000));
                endcase
                hc = ($urandom_range(19) == 0) ? {$urandom} : rand_compact();
                push_share(now, hc, rand_hash(hc));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_invalid_targets();
        test_header_only();
        test_real_time();
        test_random_mix(6);
        send_idle_pct = 57;
        recv_idle_pct = 38;
        test_random_mix(6);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(6);
        wait_drained();
        repeat (700) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
